// File: rtl/core/pbc_pkg.sv
// pbc_pkg: shared constants, codes and structs of the point boundary classifier
// no dependencies; imported by pbc_domain, pbc_cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package pbc_pkg;

    localparam int MAX_DIMS      = 4;
    localparam int MAX_OBSTACLES = 16;
    localparam int COORD_WIDTH   = 32;

    localparam int CW     = COORD_WIDTH;
    localparam int DIM_W  = 2;   // dim_index port width
    localparam int SLOT_W = 4;   // slot_index port width
    localparam int IDX_W  = 4;   // obstacle_index port width
    localparam int ACT_W  = 3;   // active_dims register width
    localparam int CNT_W  = 5;   // obstacle_count register width
    localparam int CFG_W  = 5;   // widest configuration register
    localparam int POS_W  = $clog2(MAX_OBSTACLES + 1);

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_DOMAIN = 2'd1,
        OP_BOX    = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_ABSORB   = 2'd0,
        MODE_PERIODIC = 2'd1,
        MODE_REFLECT  = 2'd2
    } mode_t;

    typedef enum logic {
        CFG_ACTIVE_DIMS    = 1'b0,
        CFG_OBSTACLE_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        SIDE_INSIDE = 2'd0,
        SIDE_LEFT   = 2'd1,
        SIDE_RIGHT  = 2'd2
    } side_t;

    typedef struct packed {
        logic             en;
        logic [DIM_W-1:0] dim;
        logic [CW-1:0]    left;
        logic [CW-1:0]    right;
        mode_t            mode;
    } dom_wr_t;

    typedef struct packed {
        logic [MAX_DIMS-1:0][1:0]    side;
        logic [MAX_DIMS-1:0]         pmask;
        logic [MAX_DIMS-1:0]         rmask;
        logic [MAX_DIMS-1:0][CW-1:0] mapped;
        logic                        absorb;
    } dom_res_t;

    typedef struct packed {
        logic             en;
        logic [DIM_W-1:0] dim;
        logic [CW-1:0]    lower;
        logic [CW-1:0]    upper;
    } box_wr_t;

    // query word travelling down the obstacle chain
    typedef struct packed {
        logic                        valid;
        logic [POS_W-1:0]            pos;
        logic [CNT_W-1:0]            nb;
        logic [MAX_DIMS-1:0]         dmask;
        logic [MAX_DIMS-1:0][CW-1:0] coord;
        logic                        hit;
        logic [IDX_W-1:0]            idx;
    } tok_t;

endpackage

`default_nettype wire

// File: rtl/core/point_boundary_classifier_core.sv
// point_boundary_classifier_core: command front end, domain lanes and obstacle cell chain
// depends on pbc_pkg, pbc_domain and pbc_cell
// a query's word passes the chain one obstacle cell per cycle, then the output register,
// before its result strobe
// busy is high from accept until the word leaves the chain, so a new query waits for the last one
// write words give no result; a query is accepted in the strobe cycle
// reset clears busy, the strobe, both registers (4 dims, 0 obstacles) and all modes to absorb
`timescale 1ns / 1ps
`default_nettype none

module point_boundary_classifier_core
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [pbc_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  opcode,
    input  wire logic [pbc_pkg::DIM_W-1:0]   dim_index,
    input  wire logic [pbc_pkg::SLOT_W-1:0]  slot_index,
    input  wire logic signed [pbc_pkg::CW-1:0] value_a,
    input  wire logic signed [pbc_pkg::CW-1:0] value_b,
    input  wire logic [1:0]                  edge_mode,
    input  wire logic signed [pbc_pkg::CW-1:0] coord_0,
    input  wire logic signed [pbc_pkg::CW-1:0] coord_1,
    input  wire logic signed [pbc_pkg::CW-1:0] coord_2,
    input  wire logic signed [pbc_pkg::CW-1:0] coord_3,
    output logic                             result_valid,
    output logic [2*pbc_pkg::MAX_DIMS-1:0]   side_codes,
    output logic [pbc_pkg::MAX_DIMS-1:0]     periodic_mask,
    output logic [pbc_pkg::MAX_DIMS-1:0]     reflect_mask,
    output logic signed [pbc_pkg::CW-1:0]    mapped_0,
    output logic signed [pbc_pkg::CW-1:0]    mapped_1,
    output logic signed [pbc_pkg::CW-1:0]    mapped_2,
    output logic signed [pbc_pkg::CW-1:0]    mapped_3,
    output logic                             absorb,
    output logic                             obstacle_hit,
    output logic [pbc_pkg::IDX_W-1:0]        obstacle_index
);
    import pbc_pkg::*;

    localparam logic [CW:0] SAT_MAX = {2'b00, {(CW-1){1'b1}}};
    localparam logic [CW:0] SAT_MIN = {2'b11, {(CW-1){1'b0}}};

    function automatic logic [CW-1:0] sat_coord(input logic [CW:0] v);
        logic [CW:0] r;
        r = v;
        if (v[CW] != v[CW-1])
        begin
            r = v[CW] ? SAT_MIN : SAT_MAX;
        end
        return r[CW-1:0];
    endfunction

    logic [ACT_W-1:0] active_dims_reg;
    logic [CNT_W-1:0] obstacle_count_reg;
    logic             busy_reg;
    logic             result_valid_reg;

    logic [MAX_DIMS-1:0][CW-1:0] coord_in;
    logic             accept;
    logic             query_go;
    logic             dom_go;
    logic             box_go;
    logic [ACT_W-1:0] nd_eff;
    logic [CNT_W-1:0] nb_eff;
    logic [MAX_DIMS-1:0] dmask;

    dom_wr_t  dom_wr;
    dom_res_t dom_res;
    dom_res_t dom_reg;

    logic signed [CW:0] center_ext;
    logic signed [CW:0] half_ext;
    logic [CW-1:0]      box_lower;
    logic [CW-1:0]      box_upper;

    tok_t chain [MAX_OBSTACLES+1];
    tok_t last_tok;

    logic [2*MAX_DIMS-1:0]       side_reg;
    logic [MAX_DIMS-1:0]         pmask_reg;
    logic [MAX_DIMS-1:0]         rmask_reg;
    logic [MAX_DIMS-1:0][CW-1:0] mapped_reg;
    logic                        absorb_reg;
    logic                        hit_reg;
    logic [IDX_W-1:0]            idx_reg;

    assign coord_in = {coord_3, coord_2, coord_1, coord_0};
    assign accept   = start && !busy_reg;

    always_comb
    begin
        query_go = 1'b0;
        dom_go   = 1'b0;
        box_go   = 1'b0;
        case (opcode_t'(opcode))
            OP_QUERY:
            begin
                query_go = accept;
            end
            OP_DOMAIN:
            begin
                // unknown edge mode drops the whole word
                dom_go = accept && (edge_mode <= 2'(MODE_REFLECT)) &&
                         ({1'b0, dim_index} < (DIM_W+1)'(MAX_DIMS));
            end
            OP_BOX:
            begin
                box_go = accept && ({1'b0, dim_index} < (DIM_W+1)'(MAX_DIMS)) &&
                         ({1'b0, slot_index} < (SLOT_W+1)'(MAX_OBSTACLES));
            end
            default:
            begin
                query_go = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_dims_reg    <= ACT_W'(MAX_DIMS);
            obstacle_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ACTIVE_DIMS:    active_dims_reg    <= cfg_data[ACT_W-1:0];
                CFG_OBSTACLE_COUNT: obstacle_count_reg <= cfg_data[CNT_W-1:0];
                default:            active_dims_reg    <= active_dims_reg;
            endcase
        end
    end

    always_comb
    begin
        nd_eff = active_dims_reg;
        if (active_dims_reg == '0)
        begin
            nd_eff = ACT_W'(1);
        end
        else if (active_dims_reg > ACT_W'(MAX_DIMS))
        begin
            nd_eff = ACT_W'(MAX_DIMS);
        end
        nb_eff = (obstacle_count_reg > CNT_W'(MAX_OBSTACLES)) ?
                 CNT_W'(MAX_OBSTACLES) : obstacle_count_reg;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            dmask[k] = ACT_W'(k) < nd_eff;
        end
    end

    // domain lanes
    always_comb
    begin
        dom_wr.en    = dom_go;
        dom_wr.dim   = dim_index;
        dom_wr.left  = value_a;
        dom_wr.right = value_b;
        dom_wr.mode  = mode_t'(edge_mode);
    end

    pbc_domain u_domain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (dom_wr),
        .coord (coord_in),
        .dmask (dmask),
        .res   (dom_res)
    );

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            dom_reg <= dom_res;
        end
    end

    // box bounds: half length rounds toward minus infinity, bounds saturate
    assign center_ext = {value_a[CW-1], value_a};
    assign half_ext   = $signed({value_b[CW-1], value_b}) >>> 1;
    assign box_lower  = sat_coord(center_ext - half_ext);
    assign box_upper  = sat_coord(center_ext + half_ext);

    // obstacle cell chain
    always_comb
    begin
        chain[0].valid = query_go;
        chain[0].pos   = '0;
        chain[0].nb    = nb_eff;
        chain[0].dmask = dmask;
        chain[0].coord = coord_in;
        chain[0].hit   = 1'b0;
        chain[0].idx   = '0;
    end

    for (genvar i = 0; i < MAX_OBSTACLES; i++)
    begin : g_cell
        box_wr_t cell_wr;

        always_comb
        begin
            cell_wr.en    = box_go && (slot_index == SLOT_W'(i));
            cell_wr.dim   = dim_index;
            cell_wr.lower = box_lower;
            cell_wr.upper = box_upper;
        end

        pbc_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (cell_wr),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign last_tok = chain[MAX_OBSTACLES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= last_tok.valid;
            if (query_go)
            begin
                busy_reg <= 1'b1;
            end
            else if (last_tok.valid)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_tok.valid)
        begin
            side_reg   <= dom_reg.side;
            pmask_reg  <= dom_reg.pmask;
            rmask_reg  <= dom_reg.rmask;
            mapped_reg <= dom_reg.mapped;
            absorb_reg <= dom_reg.absorb || last_tok.hit;
            hit_reg    <= last_tok.hit;
            idx_reg    <= last_tok.hit ? last_tok.idx : '0;
        end
    end

    assign busy           = busy_reg;
    assign result_valid   = result_valid_reg;
    assign side_codes     = side_reg;
    assign periodic_mask  = pmask_reg;
    assign reflect_mask   = rmask_reg;
    assign mapped_0       = mapped_reg[0];
    assign mapped_1       = mapped_reg[1];
    assign mapped_2       = mapped_reg[2];
    assign mapped_3       = mapped_reg[3];
    assign absorb         = absorb_reg;
    assign obstacle_hit   = hit_reg;
    assign obstacle_index = idx_reg;

endmodule

`default_nettype wire

// File: rtl/core/pbc_domain.sv
// pbc_domain: domain edge and mode store with one classification lane per dimension
// depends on pbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pbc_domain
(
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire pbc_pkg::dom_wr_t                            wr,
    input  wire logic [pbc_pkg::MAX_DIMS-1:0][pbc_pkg::CW-1:0] coord,
    input  wire logic [pbc_pkg::MAX_DIMS-1:0]                dmask,
    output pbc_pkg::dom_res_t                                res
);
    import pbc_pkg::*;

    logic [CW-1:0] left_reg  [MAX_DIMS];
    logic [CW-1:0] right_reg [MAX_DIMS];
    mode_t         mode_reg  [MAX_DIMS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            left_reg[wr.dim]  <= wr.left;
            right_reg[wr.dim] <= wr.right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                mode_reg[k] <= MODE_ABSORB;
            end
        end
        else if (wr.en)
        begin
            mode_reg[wr.dim] <= wr.mode;
        end
    end

    always_comb
    begin
        logic le;
        logic ge;
        res = '0;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            le = $signed(coord[k]) <= $signed(left_reg[k]);
            ge = $signed(coord[k]) >= $signed(right_reg[k]);
            res.mapped[k] = coord[k];
            if (dmask[k] && (le || ge))
            begin
                // left test wins even when the edges are crossed
                res.side[k] = le ? SIDE_LEFT : SIDE_RIGHT;
                case (mode_reg[k])
                    MODE_ABSORB:
                    begin
                        res.absorb = 1'b1;
                    end
                    MODE_PERIODIC:
                    begin
                        res.pmask[k]  = 1'b1;
                        res.mapped[k] = le ? right_reg[k] : left_reg[k];
                    end
                    default:
                    begin
                        res.rmask[k] = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pbc_cell.sv
// pbc_cell: one obstacle box of the chain, tests the passing query word and forwards it
// depends on pbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pbc_cell
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pbc_pkg::box_wr_t wr,
    input  wire pbc_pkg::tok_t    tok_in,
    output pbc_pkg::tok_t         tok_out
);
    import pbc_pkg::*;

    logic [CW-1:0] lower_reg [MAX_DIMS];
    logic [CW-1:0] upper_reg [MAX_DIMS];

    logic valid_reg;
    tok_t data_reg;
    tok_t data_next;
    logic in_box;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            lower_reg[wr.dim] <= wr.lower;
            upper_reg[wr.dim] <= wr.upper;
        end
    end

    always_comb
    begin
        in_box = 1'b1;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if (tok_in.dmask[k] &&
                (($signed(tok_in.coord[k]) < $signed(lower_reg[k])) ||
                 ($signed(tok_in.coord[k]) > $signed(upper_reg[k]))))
            begin
                in_box = 1'b0;
            end
        end
    end

    always_comb
    begin
        data_next     = tok_in;
        data_next.pos = tok_in.pos + POS_W'(1);
        // the pos field is this cell's slot number
        if (!tok_in.hit && (tok_in.pos < POS_W'(tok_in.nb)) && in_box)
        begin
            data_next.hit = 1'b1;
            data_next.idx = tok_in.pos[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        tok_out       = data_reg;
        tok_out.valid = valid_reg;
    end

endmodule

`default_nettype wire
